// File: rtl/core/tsdr_pkg.sv
// ----------------------------------------------------------------------------
// tsdr_pkg
// shared types and constants for the text screen refresher
// ----------------------------------------------------------------------------
package tsdr_pkg;

  localparam int unsigned COLUMNS_DEFAULT = 80;
  localparam int unsigned ROWS_DEFAULT    = 24;

  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_CLEAR   = 2'd1;
  localparam logic [1:0] KIND_MOVE    = 2'd2;
  localparam logic [1:0] KIND_REFRESH = 2'd3;

  localparam logic [7:0] CH_ESC   = 8'd27;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_J     = 8'h4a;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_EMIT,
    ST_CLR
  } state_t;

  // tens decimal digit of a value below 100
  function automatic logic [7:0] tens_digit(input logic [6:0] v);
    logic [7:0] t;
    t = 8'd0;
    for (int i = 1; i < 10; i++) begin
      if (v >= 7'(10 * i)) t = 8'(i);
    end
    return t;
  endfunction

endpackage

// File: rtl/core/tsdr_if.sv
// ----------------------------------------------------------------------------
// tsdr_in_if / tsdr_out_if
// valid/ready channels for input items and output bytes
// ----------------------------------------------------------------------------
interface tsdr_in_if;
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [7:0]       char_code;
  logic signed [7:0] column_request;
  logic signed [7:0] row_request;
  modport source (output valid, kind, char_code, column_request, row_request, input ready);
  modport sink (input valid, kind, char_code, column_request, row_request, output ready);
endinterface

interface tsdr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;
  logic       pass_done;
  modport source (output valid, out_byte, last_byte, pass_done, input ready);
  modport sink (input valid, out_byte, last_byte, pass_done, output ready);
endinterface

// File: rtl/core/text_screen_diff_refresher.sv
// ----------------------------------------------------------------------------
// text_screen_diff_refresher
// character terminal engine with current and sent screen buffers
// ----------------------------------------------------------------------------
// One word is handled at a time. After reset a clearing pass zeroes
// every cell of both buffers before the first word is taken.
// A write goes through the read, compare and emit states before the next
// ready. A move or a refresh tick goes through them too and emits its bytes,
// and the tick on the last cell also appends the cursor sequence. A clear
// also blanks every cell from the start row down, COLUMNS per row.
// Output stalls hold the emit state. The rate is set by the single buffer
// memory port and the byte stream.
// Each buffer cell is 16 bits in one ram: current in the high byte, sent low.
module text_screen_diff_refresher #(
  parameter int unsigned COLUMNS = tsdr_pkg::COLUMNS_DEFAULT,
  parameter int unsigned ROWS    = tsdr_pkg::ROWS_DEFAULT
) (
  input logic clk,
  input logic rst,
  tsdr_in_if.sink    in_ch,
  tsdr_out_if.source out_ch
);
  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS + 1);
  localparam int unsigned CW    = $clog2(COLUMNS + 1);
  localparam int unsigned RW    = $clog2(ROWS + 1);

  tsdr_pkg::state_t state, state_next;

  logic [AW-1:0]  addr;
  logic           we;
  logic [15:0]    wdata, rdata;
  logic [AW-1:0]  scan, clr_ptr;
  logic           init;
  logic [CW-1:0]  ccol;
  logic [RW-1:0]  crow;
  logic [1:0]     kind;
  logic [7:0]     ch;
  logic signed [7:0] colq, rowq;

  // pending byte list
  logic [7:0]     buf_b [17];
  logic [4:0]     n, idx;
  logic           done;
  logic           tail;

  logic [7:0]     obyte;
  logic           ovalid, olast, odone;

  tsdr_ram #(.WIDTH(16), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  function automatic logic [CW-1:0] clampc(input logic signed [7:0] v);
    if (v < 0) return '0;
    if (32'(v) >= COLUMNS) return CW'(COLUMNS - 1);
    return CW'(v);
  endfunction
  function automatic logic [RW-1:0] clampr(input logic signed [7:0] v);
    if (v < 0) return '0;
    if (32'(v) >= ROWS) return RW'(ROWS - 1);
    return RW'(v);
  endfunction

  // scan position split into row and column, tracked incrementally
  logic [CW-1:0] scol;
  logic [RW-1:0] srow;

  // position sequence builder inputs
  logic [6:0] pr, pc;
  logic [7:0] seq [8];
  logic [3:0] seqn;
  always_comb begin
    logic [7:0] rt, ct;
    rt = tsdr_pkg::tens_digit(pr);
    ct = tsdr_pkg::tens_digit(pc);
    for (int i = 0; i < 8; i++) seq[i] = 8'd0;
    seqn = 4'd0;
    seq[3'(seqn)] = tsdr_pkg::CH_ESC;  seqn = seqn + 4'd1;
    seq[3'(seqn)] = tsdr_pkg::CH_LBRK; seqn = seqn + 4'd1;
    if (pr >= 7'd10) begin seq[3'(seqn)] = tsdr_pkg::CH_ZERO + rt; seqn = seqn + 4'd1; end
    seq[3'(seqn)] = tsdr_pkg::CH_ZERO + 8'(pr) - 8'(rt * 8'd10); seqn = seqn + 4'd1;
    seq[3'(seqn)] = tsdr_pkg::CH_SEMI; seqn = seqn + 4'd1;
    if (pc >= 7'd10) begin seq[3'(seqn)] = tsdr_pkg::CH_ZERO + ct; seqn = seqn + 4'd1; end
    seq[3'(seqn)] = tsdr_pkg::CH_ZERO + 8'(pc) - 8'(ct * 8'd10); seqn = seqn + 4'd1;
    seq[3'(seqn)] = tsdr_pkg::CH_H;    seqn = seqn + 4'd1;
  end

  logic last_cell;
  assign last_cell = (32'(scan) + 1 >= CELLS);
  logic changed;
  assign changed = rdata[15:8] != rdata[7:0];

  always_comb begin
    pr = 7'(crow) + 7'd1;
    pc = 7'(ccol) + 7'd1;
    if (state == tsdr_pkg::ST_CMP && kind == tsdr_pkg::KIND_REFRESH && changed
        && idx == 5'd0) begin
      pr = 7'(srow) + 7'd1;
      pc = 7'(scol) + 7'd1;
    end else if (state == tsdr_pkg::ST_CMP && kind == tsdr_pkg::KIND_CLEAR) begin
      pr = 7'(clampr(rowq)) + 7'd1;
      pc = 7'd1;
    end else if (state == tsdr_pkg::ST_CMP && kind == tsdr_pkg::KIND_MOVE) begin
      pr = 7'(clampr(rowq)) + 7'd1;
      pc = 7'(clampc(colq)) + 7'd1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tsdr_pkg::ST_IDLE: if (!init && in_ch.valid) state_next = tsdr_pkg::ST_RD;
      tsdr_pkg::ST_RD:   state_next = tsdr_pkg::ST_CMP;
      tsdr_pkg::ST_CMP:  state_next = (kind == tsdr_pkg::KIND_CLEAR) ? tsdr_pkg::ST_CLR
                                                                    : tsdr_pkg::ST_EMIT;
      tsdr_pkg::ST_CLR:  if (32'(clr_ptr) + 1 >= CELLS) state_next = tsdr_pkg::ST_EMIT;
      tsdr_pkg::ST_EMIT: if (!tail && idx >= n && (!ovalid || out_ch.ready))
                           state_next = tsdr_pkg::ST_IDLE;
      default:           state_next = tsdr_pkg::ST_IDLE;
    endcase
  end

  // memory port
  always_comb begin
    we = 1'b0;
    wdata = '0;
    addr = scan;
    if (init) begin
      we = 1'b1; addr = clr_ptr;
    end else begin
      unique case (state)
        tsdr_pkg::ST_RD: addr = (kind == tsdr_pkg::KIND_WRITE)
                                ? AW'(32'(crow) * COLUMNS + 32'(ccol)) : scan;
        tsdr_pkg::ST_CMP: begin
          if (kind == tsdr_pkg::KIND_WRITE && ch != tsdr_pkg::CH_NL &&
              ch != tsdr_pkg::CH_BS && ch != tsdr_pkg::CH_DEL) begin
            addr = AW'(32'(crow) * COLUMNS + 32'(ccol));
            we = 1'b1; wdata = {ch, rdata[7:0]};
          end else if (kind == tsdr_pkg::KIND_REFRESH) begin
            addr = scan; we = 1'b1; wdata = {rdata[15:8], rdata[15:8]};
          end
        end
        tsdr_pkg::ST_CLR: begin
          addr = clr_ptr; we = 1'b1; wdata = {tsdr_pkg::CH_SPACE, tsdr_pkg::CH_SPACE};
        end
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state == tsdr_pkg::ST_IDLE) && !init;
  assign out_ch.valid = ovalid;
  assign out_ch.out_byte = obyte;
  assign out_ch.last_byte = olast;
  assign out_ch.pass_done = odone;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsdr_pkg::ST_IDLE;
      init <= 1'b1;
      clr_ptr <= '0;
      scan <= '0; scol <= '0; srow <= '0;
      crow <= '0; ccol <= '0;
      ovalid <= 1'b0; n <= '0; idx <= '0; done <= 1'b0; tail <= 1'b0;
    end else begin
      state <= state_next;
      if (init) begin
        clr_ptr <= clr_ptr + AW'(1);
        if (32'(clr_ptr) + 1 >= CELLS) init <= 1'b0;
      end
      unique case (state)
        tsdr_pkg::ST_IDLE: if (in_ch.valid && !init) begin
          kind <= in_ch.kind; ch <= in_ch.char_code;
          colq <= in_ch.column_request; rowq <= in_ch.row_request;
          n <= '0; idx <= '0; done <= 1'b0; tail <= 1'b0;
        end
        tsdr_pkg::ST_RD: ;
        tsdr_pkg::ST_CMP: begin
          unique case (kind)
            tsdr_pkg::KIND_WRITE: begin
              if (ch == tsdr_pkg::CH_NL) begin
                ccol <= '0;
                if (32'(crow) + 1 < ROWS) crow <= crow + RW'(1);
              end else if (ch == tsdr_pkg::CH_BS || ch == tsdr_pkg::CH_DEL) begin
                if (ccol != '0) ccol <= ccol - CW'(1);
              end else if (32'(ccol) + 1 >= COLUMNS) begin
                ccol <= '0;
                if (32'(crow) + 1 < ROWS) crow <= crow + RW'(1);
              end else ccol <= ccol + CW'(1);
            end
            tsdr_pkg::KIND_CLEAR: begin
              for (int i = 0; i < 8; i++) if (4'(i) < seqn) buf_b[i] <= seq[i];
              buf_b[5'(seqn)] <= tsdr_pkg::CH_ESC;
              buf_b[5'(seqn) + 5'd1] <= tsdr_pkg::CH_LBRK;
              buf_b[5'(seqn) + 5'd2] <= tsdr_pkg::CH_J;
              n <= 5'(seqn) + 5'd3;
              clr_ptr <= AW'(32'(clampr(rowq)) * COLUMNS);
              ccol <= '0; crow <= clampr(rowq);
            end
            tsdr_pkg::KIND_MOVE: begin
              for (int i = 0; i < 8; i++) if (4'(i) < seqn) buf_b[i] <= seq[i];
              n <= 5'(seqn);
              ccol <= clampc(colq); crow <= clampr(rowq);
            end
            default: begin
              if (changed) begin
                for (int i = 0; i < 8; i++) if (4'(i) < seqn) buf_b[i] <= seq[i];
                buf_b[5'(seqn)] <= rdata[15:8];
                n <= 5'(seqn) + 5'd1;
              end
              if (last_cell) begin
                done <= 1'b1;
                tail <= 1'b1;
                scan <= '0; scol <= '0; srow <= '0;
              end else begin
                scan <= scan + AW'(1);
                if (32'(scol) + 1 >= COLUMNS) begin
                  scol <= '0; srow <= srow + RW'(1);
                end else scol <= scol + CW'(1);
              end
            end
          endcase
        end
        tsdr_pkg::ST_CLR: clr_ptr <= clr_ptr + AW'(1);
        tsdr_pkg::ST_EMIT: begin
          if (tail) begin
            // cursor position after the last cell
            for (int i = 0; i < 8; i++) if (4'(i) < seqn) buf_b[n + 5'(i)] <= seq[i];
            n <= n + 5'(seqn);
            tail <= 1'b0;
          end else if ((!ovalid || out_ch.ready) && idx < n) begin
            obyte <= buf_b[idx];
            olast <= (idx + 5'd1 == n);
            odone <= done;
            ovalid <= 1'b1;
            idx <= idx + 5'd1;
          end else if (out_ch.ready) begin
            ovalid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// File: rtl/core/tsdr_ram.sv
// ----------------------------------------------------------------------------
// tsdr_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module tsdr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1920
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
